// File: design/timed_keyed_entry_queue_macros.svh
// Assertion macros for the timed keyed entry queue.
// Each macro expands to one labeled concurrent assertion, disabled while the active-low reset is low.
`ifndef TIMED_KEYED_ENTRY_QUEUE_MACROS_SVH
`define TIMED_KEYED_ENTRY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tkq_pkg.sv
// Shared types and constants for the timed keyed entry queue.
// Depends on nothing; the top level imports it.
`default_nettype none

package tkq_pkg;

    // Default ring depth.
    localparam int DEPTH_DEFAULT = 8;

    // Field widths.
    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 24;
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 3;
    localparam int REASON_W = 2;

    // Reset value of the lifetime register.
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(5000);

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISMISS = 3'd4;

    // Reasons reported with a removed key.
    localparam logic [REASON_W-1:0] RSN_EXPIRED   = 2'd0;
    localparam logic [REASON_W-1:0] RSN_DISMISSED = 2'd1;
    localparam logic [REASON_W-1:0] RSN_REQUEST   = 2'd2;
    localparam logic [REASON_W-1:0] RSN_EVICTED   = 2'd3;

    // One stored entry.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] deadline;
        logic              expanded;
    } t_entry;

endpackage

`default_nettype wire

// File: design/timed_keyed_entry_queue.sv
// Timed keyed entry queue: an age-ordered ring of keyed entries with deadlines, in one memory.
// Steps: a request is taken in idle; each entry searched or expired is read, then evaluated; each
// entry shifted after a removal is checked, read and written, then a last check ends the shift; an
// append may first read and report an evicted entry; a tick is closed; each result is loaded into
// the output register. One request at a time, held off until idle and by output stalls; the entry
// memory has a single read port. Synchronous active-low reset empties the ring at once.
`default_nettype none

`include "timed_keyed_entry_queue_macros.svh"

module timed_keyed_entry_queue
    import tkq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration write channel.
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [TMO_W-1:0]    i_cfg_data,
    // Request channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [KEY_W-1:0]    i_key_id,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [TIME_W-1:0]   i_now_time,
    // Result channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [KEY_W-1:0]         o_closed_key,
    output logic [REASON_W-1:0]      o_close_reason,
    output logic                     o_last
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int PW   = CW + 1;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_READ       = 4'd1;
    localparam logic [3:0] S_SCAN_EV    = 4'd2;
    localparam logic [3:0] S_APPEND     = 4'd3;
    localparam logic [3:0] S_EVICT_EV   = 4'd4;
    localparam logic [3:0] S_APPEND_WR  = 4'd5;
    localparam logic [3:0] S_SHIFT_CHK  = 4'd6;
    localparam logic [3:0] S_SHIFT_WR   = 4'd7;
    localparam logic [3:0] S_TICK_EV    = 4'd8;
    localparam logic [3:0] S_TICK_FIN   = 4'd9;
    localparam logic [3:0] S_TOGGLE_EV  = 4'd10;
    localparam logic [3:0] S_DISMISS_EV = 4'd11;
    localparam logic [3:0] S_EMIT       = 4'd12;

    // Ring position plus an offset, wrapped once.
    function automatic logic [AW-1:0] pos_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [PW-1:0] s;
        s = PW'(base) + PW'(off);
        if (s >= PW'(DEPTH)) s = s - PW'(DEPTH);
        return s[AW-1:0];
    endfunction

    // Control registers.
    logic [3:0]          r_state, n_state;
    logic [3:0]          r_ret, n_ret;
    logic [AW-1:0]       r_wp, n_wp;
    logic [CW-1:0]       r_count, n_count;
    logic [TMO_W-1:0]    r_timeout;
    logic                r_out_valid, n_out_valid;
    logic                r_pend_valid, n_pend_valid;

    // Working registers.
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_dst, n_dst;
    logic [CW-1:0]       r_age, n_age;
    logic [KEY_W-1:0]    r_pend_key, n_pend_key;
    logic [KEY_W-1:0]    r_emit_key, n_emit_key;
    logic [REASON_W-1:0] r_emit_reason, n_emit_reason;
    logic                r_emit_last, n_emit_last;
    logic [KEY_W-1:0]    r_out_key, n_out_key;
    logic [REASON_W-1:0] r_out_reason, n_out_reason;
    logic                r_out_last, n_out_last;

    // Entry memory with a registered read port.
    t_entry              mem [DEPTH];
    t_entry              r_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    t_entry              mem_wd;

    // Derived values.
    logic [AW-1:0]       oldest;
    logic [PW-1:0]       oldest_sum;
    logic [TIME_W:0]     dl_sum;
    logic [TIME_W-1:0]   deadline_new;
    logic                in_accept;
    logic                out_free;
    logic                slot_live;
    logic                due;
    logic [CW-1:0]       count_dec;

    // Oldest live position: write pointer minus entry count, modulo depth.
    always_comb begin
        oldest_sum = PW'(r_wp) + PW'(DEPTH) - PW'(r_count);
        if (oldest_sum >= PW'(DEPTH)) begin
            oldest_sum = oldest_sum - PW'(DEPTH);
        end
        oldest = oldest_sum[AW-1:0];
    end

    // Saturating deadline for a push.
    assign dl_sum       = {1'b0, r_now} + (TIME_W + 1)'(r_timeout);
    assign deadline_new = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign slot_live = CMPW'(i_slot) < CMPW'(r_count);
    assign due       = !r_rd.expanded && (r_rd.deadline < r_now);
    assign count_dec = r_count - CW'(1);

    // Sequencer: read, evaluate and write back one entry at a time.
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_wp          = r_wp;
        n_count       = r_count;
        n_pend_valid  = r_pend_valid;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_now         = r_now;
        n_pos         = r_pos;
        n_dst         = r_dst;
        n_age         = r_age;
        n_pend_key    = r_pend_key;
        n_emit_key    = r_emit_key;
        n_emit_reason = r_emit_reason;
        n_emit_last   = r_emit_last;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_key     = r_out_key;
        n_out_reason  = r_out_reason;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;
        mem_wa        = r_pos;
        mem_wd        = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd = i_cmd;
                    n_key = i_key_id;
                    n_now = i_now_time;
                    n_age = '0;
                    n_pos = oldest;
                    unique case (i_cmd) inside
                        CMD_PUSH: begin
                            if (i_key_id != '0 && r_count != '0) begin
                                n_state = S_READ;
                                n_ret   = S_SCAN_EV;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        CMD_CLOSE: begin
                            if (r_count != '0) begin
                                n_state = S_READ;
                                n_ret   = S_SCAN_EV;
                            end
                        end
                        CMD_TICK: begin
                            if (r_count != '0) begin
                                n_state = S_READ;
                                n_ret   = S_TICK_EV;
                            end
                        end
                        CMD_TOGGLE, CMD_DISMISS: begin
                            if (slot_live) begin
                                n_age   = CW'(i_slot);
                                n_pos   = pos_add(oldest, CW'(i_slot));
                                n_state = S_READ;
                                n_ret   = (i_cmd == CMD_TOGGLE) ? S_TOGGLE_EV : S_DISMISS_EV;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Read data for r_pos lands in r_rd at the end of this cycle.
            S_READ: begin
                n_state = r_ret;
            end

            // Key search for a push refresh or a close by key.
            S_SCAN_EV: begin
                if (r_rd.key == r_key) begin
                    if (r_cmd == CMD_PUSH) begin
                        mem_we  = 1'b1;
                        mem_wd  = '{key: r_rd.key, deadline: deadline_new, expanded: 1'b0};
                        n_state = S_IDLE;
                    end else begin
                        n_emit_key    = r_rd.key;
                        n_emit_reason = RSN_REQUEST;
                        n_emit_last   = 1'b1;
                        n_dst         = r_pos;
                        n_state       = S_EMIT;
                        n_ret         = S_SHIFT_CHK;
                    end
                end else if (r_age + CW'(1) == r_count) begin
                    n_state = (r_cmd == CMD_PUSH) ? S_APPEND : S_IDLE;
                end else begin
                    n_age   = r_age + CW'(1);
                    n_pos   = pos_add(r_pos, CW'(1));
                    n_state = S_READ;
                    n_ret   = S_SCAN_EV;
                end
            end

            // A full ring first reports the oldest entry, which sits at the write pointer.
            S_APPEND: begin
                if (r_count == CW'(DEPTH)) begin
                    n_pos   = r_wp;
                    n_state = S_READ;
                    n_ret   = S_EVICT_EV;
                end else begin
                    n_state = S_APPEND_WR;
                end
            end

            S_EVICT_EV: begin
                n_emit_key    = r_rd.key;
                n_emit_reason = RSN_EVICTED;
                n_emit_last   = 1'b1;
                n_state       = S_EMIT;
                n_ret         = S_APPEND_WR;
            end

            S_APPEND_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_wp;
                mem_wd  = '{key: r_key, deadline: deadline_new, expanded: 1'b0};
                n_wp    = pos_add(r_wp, CW'(1));
                if (r_count != CW'(DEPTH)) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end

            // Close the gap: move each younger entry one position toward the oldest.
            S_SHIFT_CHK: begin
                if (r_age + CW'(1) < r_count) begin
                    n_pos   = pos_add(r_dst, CW'(1));
                    n_state = S_READ;
                    n_ret   = S_SHIFT_WR;
                end else begin
                    n_wp    = pos_add(r_wp, CW'(DEPTH - 1));
                    n_count = count_dec;
                    n_state = S_IDLE;
                end
            end

            S_SHIFT_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_dst;
                mem_wd  = r_rd;
                n_dst   = r_pos;
                n_age   = r_age + CW'(1);
                n_state = S_SHIFT_CHK;
            end

            // Expiry walk; each result is held back until the next decision sets its last flag.
            S_TICK_EV: begin
                if (due) begin
                    n_count      = count_dec;
                    n_pos        = pos_add(r_pos, CW'(1));
                    n_pend_key   = r_rd.key;
                    n_pend_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_emit_key    = r_pend_key;
                        n_emit_reason = RSN_EXPIRED;
                        n_emit_last   = 1'b0;
                        n_state       = S_EMIT;
                        n_ret         = (count_dec != '0) ? S_READ : S_TICK_FIN;
                    end else begin
                        n_state = (count_dec != '0) ? S_READ : S_TICK_FIN;
                    end
                    if (count_dec != '0) begin
                        n_ret = (r_pend_valid) ? S_READ : S_TICK_EV;
                    end
                end else begin
                    n_state = S_TICK_FIN;
                end
            end

            S_TICK_FIN: begin
                if (r_pend_valid) begin
                    n_emit_key    = r_pend_key;
                    n_emit_reason = RSN_EXPIRED;
                    n_emit_last   = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_state       = S_EMIT;
                    n_ret         = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_TOGGLE_EV: begin
                mem_we  = 1'b1;
                mem_wd  = '{key: r_rd.key, deadline: r_rd.deadline, expanded: !r_rd.expanded};
                n_state = S_IDLE;
            end

            S_DISMISS_EV: begin
                n_emit_key    = r_rd.key;
                n_emit_reason = RSN_DISMISSED;
                n_emit_last   = 1'b1;
                n_dst         = r_pos;
                n_state       = S_EMIT;
                n_ret         = S_SHIFT_CHK;
            end

            // Hand a result to the output register once it is free.
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_emit_key;
                    n_out_reason = r_emit_reason;
                    n_out_last   = r_emit_last;
                    n_state      = (r_ret == S_READ) ? S_READ : r_ret;
                    if (r_ret == S_READ) begin
                        n_ret = S_TICK_EV;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_pos];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_count      <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_ret         <= n_ret;
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_now         <= n_now;
        r_pos         <= n_pos;
        r_dst         <= n_dst;
        r_age         <= n_age;
        r_pend_key    <= n_pend_key;
        r_emit_key    <= n_emit_key;
        r_emit_reason <= n_emit_reason;
        r_emit_last   <= n_emit_last;
        r_out_key     <= n_out_key;
        r_out_reason  <= n_out_reason;
        r_out_last    <= n_out_last;
    end

    // Ports.
    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_closed_key   = r_out_key;
    assign o_close_reason = r_out_reason;
    assign o_last         = r_out_last;

    // Checks on the sequencer.
    `TKQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count overflow")
    `TKQ_ASSERT_SAME(a_pend_in_tick, i_clk, i_rst_n, r_pend_valid, r_state == S_TICK_EV || r_state == S_READ || r_state == S_EMIT || r_state == S_TICK_FIN, "held result outside tick")
    `TKQ_ASSERT_NEXT(a_empty_tick, i_clk, i_rst_n, in_accept && i_cmd == CMD_TICK && r_count == '0, r_state == S_IDLE, "tick on empty ring did not finish")
    `TKQ_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, r_state == S_APPEND_WR && r_count != CW'(DEPTH), r_count == $past(r_count) + CW'(1), "append did not grow ring")

endmodule

`default_nettype wire
